// File: sv/spq_pkg.sv
// Package for the stable priority queue: entry type, command, status and cell op codes.
`default_nettype none
package spq_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned PrioW  = 16;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_DELETE  = 2'd1,
    CMD_DISPLAY = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_INSERTED = 3'd0,
    STAT_DELETED  = 3'd1,
    STAT_SHOWN    = 3'd2,
    STAT_EMPTY    = 3'd3,
    STAT_FULL     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_ROTATE = 2'd2
  } cell_op_e;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic signed [PrioW-1:0]  prio;
  } entry_t;

  typedef struct packed {
    cell_op_e op;
    entry_t   item;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// File: sv/spq_cell.sv
// One slot of the sorted chain: compares, keeps, or takes a neighbor's entry.
`default_nettype none
module spq_cell (
  input  wire logic               clk_i,
  input  wire spq_pkg::cell_ctrl_t ctrl_i,
  input  wire logic               occ_i,
  input  wire logic               wrap_i,
  input  wire logic               left_keep_i,
  input  wire spq_pkg::entry_t    left_entry_i,
  input  wire spq_pkg::entry_t    right_entry_i,
  input  wire spq_pkg::entry_t    head_entry_i,
  output spq_pkg::entry_t         entry_o,
  output logic                    keep_o
);

  spq_pkg::entry_t entry_q, entry_d;

  // stays in place on insert: occupied and not lower than the new item
  assign keep_o  = occ_i && (entry_q.prio >= ctrl_i.item.prio);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      spq_pkg::OP_INSERT: begin
        if (!keep_o) begin
          entry_d = left_keep_i ? ctrl_i.item : left_entry_i;
        end
      end
      spq_pkg::OP_ROTATE: begin
        entry_d = wrap_i ? head_entry_i : right_entry_i;
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule
`default_nettype wire

// File: sv/stable_priority_queue.sv
// Stable sorted priority queue top level: command control, output register, cell chain.
//
// Input channel (in_valid_i/in_ready_o) takes one command per transfer:
// insert, delete head, or display. Output channel (out_valid_o/out_ready_i)
// returns results with status, value, priority and a last flag.
// For insert and delete the result is registered in the cycle after the
// input transfer and the chain updates in that same cycle. Insert goes
// behind all entries of equal or higher priority, so ties leave in FIFO order.
// Display returns one entry per cycle from head to tail, while the receiver
// keeps up, by rotating the chain through its head; afterwards the chain is
// back in order. A display holds the input until its last entry is out; other
// commands allow a new transfer every cycle while the receiver keeps up.
// Empty delete/display give an empty status; insert into a full queue gives
// a full status and changes nothing. Unused command codes give no result.
// Reset empties the queue and drops any pending result. When the receiver
// stalls, the result is held and no new command is accepted.
`default_nettype none
module stable_priority_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  command_i,
  input  wire logic signed [31:0] item_value_i,
  input  wire logic signed [15:0] item_priority_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic signed [31:0] out_value_o,
  output logic signed [15:0] out_priority_o,
  output logic             last_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DISP = 1'b1;

  logic            state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  logic [2:0]      status_q, status_d;
  spq_pkg::entry_t res_q, res_d;
  logic            last_q, last_d;

  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::entry_t     entries [DEPTH];
  logic [DEPTH-1:0]    keeps;
  spq_pkg::entry_t     head;

  logic out_free, acc, full, empty, disp_last;

  assign head      = entries[0];
  assign out_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign acc       = in_valid_i && in_ready_o;
  assign full      = (count_q == CntW'(DEPTH));
  assign empty     = (count_q == '0);
  assign disp_last = (idx_q + CntW'(1)) == count_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    status_d    = status_q;
    res_d       = res_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ctrl.op         = spq_pkg::OP_HOLD;
    ctrl.item.value = item_value_i;
    ctrl.item.prio  = item_priority_i;

    if (acc) begin
      case (command_i)
        spq_pkg::CMD_INSERT: begin
          out_valid_d = 1'b1;
          last_d      = 1'b1;
          res_d       = '0;
          if (full) begin
            status_d = spq_pkg::STAT_FULL;
          end else begin
            status_d = spq_pkg::STAT_INSERTED;
            ctrl.op  = spq_pkg::OP_INSERT;
            count_d  = count_q + CntW'(1);
          end
        end
        spq_pkg::CMD_DELETE: begin
          out_valid_d = 1'b1;
          last_d      = 1'b1;
          if (empty) begin
            status_d = spq_pkg::STAT_EMPTY;
            res_d    = '0;
          end else begin
            status_d = spq_pkg::STAT_DELETED;
            res_d    = head;
            ctrl.op  = spq_pkg::OP_ROTATE;
            count_d  = count_q - CntW'(1);
          end
        end
        spq_pkg::CMD_DISPLAY: begin
          if (empty) begin
            out_valid_d = 1'b1;
            last_d      = 1'b1;
            status_d    = spq_pkg::STAT_EMPTY;
            res_d       = '0;
          end else begin
            state_d = ST_DISP;
            idx_d   = '0;
          end
        end
        default: begin
          state_d = state_q;
        end
      endcase
    end else if (state_q == ST_DISP && out_free) begin
      out_valid_d = 1'b1;
      status_d    = spq_pkg::STAT_SHOWN;
      res_d       = head;
      last_d      = disp_last;
      ctrl.op     = spq_pkg::OP_ROTATE;
      idx_d       = idx_q + CntW'(1);
      if (disp_last) begin
        state_d = ST_IDLE;
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::entry_t left_entry, right_entry;
    logic            left_keep;
    if (i == 0) begin : g_first
      assign left_entry = ctrl.item;
      assign left_keep  = 1'b1;
    end else begin : g_mid
      assign left_entry = entries[i-1];
      assign left_keep  = keeps[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_entry = head;
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end
    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occ_i        (count_q > CntW'(i)),
      .wrap_i       (count_q == CntW'(i + 1)),
      .left_keep_i  (left_keep),
      .left_entry_i (left_entry),
      .right_entry_i(right_entry),
      .head_entry_i (head),
      .entry_o      (entries[i]),
      .keep_o       (keeps[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    res_q    <= res_d;
    last_q   <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_value_o    = res_q.value;
  assign out_priority_o = res_q.prio;
  assign last_o         = last_q;

endmodule
`default_nettype wire
